// ===== sv/cfq_pkg.sv =====
// ----------------------------------------------------------------------------
// cfq_pkg: shared constants for the circular FIFO queue
// Widths, operation codes and status codes used by the queue and its RAM.
// ----------------------------------------------------------------------------
package cfq_pkg;

    localparam int DEPTH    = 16;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int WORD_W   = 32;
    localparam int FUNC_W   = 2;
    localparam int STAT_W   = 2;
    localparam int CAP_W    = 5;

    // front, rear, occupancy, empty, full, padded to whole bytes
    localparam int RES_W    = 2 * WORD_W + CNT_W + 2;
    localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FN_QUERY = 2'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_POP   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

// ===== sv/cfq_ram.sv =====
// ----------------------------------------------------------------------------
// cfq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/circular_fifo_queue.sv =====
// ----------------------------------------------------------------------------
// circular_fifo_queue: ring-buffer FIFO of signed 32-bit words
// Queries, enqueues and dequeues words, reporting status after every transfer.
// ----------------------------------------------------------------------------
// Result: registered from the input transfer; a dequeue that leaves words
//   behind first reads the new front word from the slot RAM in S_READ.
// Throughput: 1 item per cycle for query and enqueue unless the result
//   stream stalls; no input is taken in S_READ (single RAM read port).
// Reset: pointers and count clear, capacity returns to 16; RAM is not cleared.
// ----------------------------------------------------------------------------
module circular_fifo_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write: capacity
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cfq_pkg::CAP_W-1:0]     cfg_data,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [cfq_pkg::WORD_W-1:0]    s_axis_tdata,  // [31:0] push_value
    input  logic [cfq_pkg::FUNC_W-1:0]    s_axis_tuser,  // [1:0] func
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] front_value, [63:32] rear_value, [68:64] occupancy,
    // [69] is_empty, [70] is_full, [71] zero
    output logic [cfq_pkg::M_DATA_W-1:0]  m_axis_tdata,
    output logic [cfq_pkg::STAT_W-1:0]    m_axis_tuser   // [1:0] status
);

    localparam int PTR_W  = cfq_pkg::PTR_W;
    localparam int CNT_W  = cfq_pkg::CNT_W;
    localparam int WORD_W = cfq_pkg::WORD_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic                        state_reg, state_next;
    logic [PTR_W-1:0]            head_reg, head_next;
    logic [PTR_W-1:0]            tail_reg, tail_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            cap_reg, cap_next;
    logic [WORD_W-1:0]           front_reg, front_next;
    logic [WORD_W-1:0]           rear_reg, rear_next;
    logic                        out_valid_reg, out_valid_next;
    logic [cfq_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;
    logic [cfq_pkg::STAT_W-1:0]  out_user_reg, out_user_next;

    logic                        in_xfer;
    logic                        is_full_now;
    logic                        ram_we;
    logic [PTR_W-1:0]            ram_waddr;
    logic [PTR_W-1:0]            ram_raddr;
    logic [WORD_W-1:0]           ram_rdata;

    // result load
    logic                        ld;
    logic [cfq_pkg::STAT_W-1:0]  ld_status;
    logic [CNT_W-1:0]            ld_count;
    logic [WORD_W-1:0]           ld_front;
    logic [WORD_W-1:0]           ld_rear;
    logic                        ld_empty;
    logic                        ld_full;

    // Advance a pointer by one slot, wrapping after slot capacity-1.
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] n;
        n = CNT_W'(p) + CNT_W'(1);
        return (n >= cap) ? '0 : n[PTR_W-1:0];
    endfunction

    // Clamp a written capacity into 1..DEPTH.
    function automatic logic [CNT_W-1:0] clamp_cap(input logic [cfq_pkg::CAP_W-1:0] v);
        logic [CNT_W-1:0] c;
        c = CNT_W'(v);
        if (v == '0)
        begin
            c = CNT_W'(1);
        end
        else if (v > cfq_pkg::CAP_W'(cfq_pkg::DEPTH))
        begin
            c = CNT_W'(cfq_pkg::DEPTH);
        end
        return c;
    endfunction

    cfq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (cfq_pkg::DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_axis_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Accept only when idle and the result register is free or draining.
    assign s_axis_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign is_full_now   = (count_reg == cap_reg);
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        cap_next       = cap_reg;
        front_next     = front_reg;
        rear_next      = rear_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        ram_we         = 1'b0;
        ram_waddr      = tail_reg;
        ram_raddr      = head_reg;
        ld             = 1'b0;
        ld_status      = cfq_pkg::STAT_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    ld = 1'b1;
                    case (s_axis_tuser)
                        cfq_pkg::FN_PUSH:
                        begin
                            if (is_full_now)
                            begin
                                ld_status = cfq_pkg::STAT_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                // First word always lands in slot zero.
                                head_next  = '0;
                                tail_next  = '0;
                                count_next = CNT_W'(1);
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                                front_next = s_axis_tdata;
                                rear_next  = s_axis_tdata;
                            end
                            else
                            begin
                                tail_next  = advance(tail_reg, cap_reg);
                                count_next = count_reg + CNT_W'(1);
                                ram_we     = 1'b1;
                                ram_waddr  = tail_next;
                                rear_next  = s_axis_tdata;
                            end
                        end
                        cfq_pkg::FN_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                ld_status = cfq_pkg::STAT_EMPTY;
                            end
                            else if (count_reg == CNT_W'(1))
                            begin
                                head_next  = '0;
                                tail_next  = '0;
                                count_next = '0;
                            end
                            else
                            begin
                                // Fetch the new front word; the result is loaded from it in S_READ.
                                head_next  = advance(head_reg, cap_reg);
                                count_next = count_reg - CNT_W'(1);
                                ram_raddr  = head_next;
                                ld         = 1'b0;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            ld_status = cfq_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                front_next = ram_rdata;
                ld         = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A capacity write clears the queue; the user must send it only while idle, as the block does not enforce it.
        if (cfg_valid && cfg_ready)
        begin
            cap_next   = clamp_cap(cfg_data);
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end

        ld_count = count_next;
        ld_empty = (count_next == '0);
        ld_full  = (count_next == cap_reg);
        ld_front = ld_empty ? '1 : front_next;
        ld_rear  = ld_empty ? '1 : rear_next;

        out_data_next = out_data_reg;
        out_user_next = out_user_reg;
        if (ld)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {1'b0, ld_full, ld_empty, ld_count, ld_rear, ld_front};
            out_user_next  = ld_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= CNT_W'(cfq_pkg::CAP_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: hold front/rear words and the result, no reset needed.
    always_ff @(posedge clk)
    begin
        front_reg    <= front_next;
        rear_reg     <= rear_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

`ifndef SYNTHESIS
    a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("occupancy exceeds capacity");

    a_empty_ptrs_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == '0 && tail_reg == '0))
        else $error("empty queue with nonzero pointers");

    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> !out_valid_reg)
        else $error("result register busy when front word returns");

    a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("front read did not produce a result");

    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_user_reg == cfq_pkg::STAT_FULL) |-> out_data_reg[70])
        else $error("enqueue rejected while not full");
`endif

endmodule
